// ----- sv/fpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants of the four-level page table engine.
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int unsigned IDX_W   = 9;
    localparam int unsigned VA_W    = 48;
    localparam int unsigned PF_W    = 40;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_PROTECT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_MAPPED   = 2'd2,
        ST_ABSENT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EVAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [PA_W-1:0] xlat_addr;
        logic [PF_W-1:0] old_frame;
        logic [11:0]     old_flags;
        logic            old_no_exec;
        logic            tlb_flush;
        logic [1:0]      status;
    } t_result;

    function automatic logic [ENTRY_W-1:0] leaf_flags(input logic [2:0] prot);
        logic [ENTRY_W-1:0] f;
        f     = '0;
        f[0]  = 1'b1;
        f[1]  = prot[0];
        f[2]  = prot[1];
        f[63] = ~prot[2];
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fpt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fpt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- sv/four_level_page_table_engine.sv -----
`default_nettype none
// Each of the four table levels passes through read, wait and evaluate states; the
// result is presented in S_OUT, earlier when an entry is absent or no frame is free.
// No new command is accepted while a walk runs or while its result is stalled;
// the next command is taken once the result leaves.
// After reset the store is cleared one entry per cycle, all TABLE_FRAMES*512 entries,
// while no command is accepted.
// ----------------------------------------------------------------------------
// four_level_page_table_engine
// Walks, creates and updates a four-level radix page table held in one RAM.
// ----------------------------------------------------------------------------
module four_level_page_table_engine
    import fpt_pkg::*;
#(
    parameter int unsigned TABLE_FRAMES = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], virt_addr[49:2], phys_frame[89:50], protection[92:90], pad
    input  wire  [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status[1:0], xlat_addr[53:2], old_frame[93:54], old_flags[105:94],
    // old_no_exec[106], tlb_flush[107], pad
    output logic [111:0] m_axis_tdata
);
    localparam int unsigned TF_W  = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int unsigned DEPTH = TABLE_FRAMES * 512;
    localparam int unsigned AW    = TF_W + IDX_W;
    localparam int unsigned CNT_W = TF_W + 1;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0] r_free, n_free;
    logic [1:0]       r_cmd, n_cmd;
    logic [VA_W-1:0]  r_va, n_va;
    logic [PF_W-1:0]  r_pf, n_pf;
    logic [2:0]       r_prot, n_prot;
    logic [1:0]       r_lvl, n_lvl;   // 3 = top level, 0 = leaf
    logic [TF_W-1:0]  r_tbl, n_tbl;
    t_result          r_res, n_res;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [63:0]      ram_wdata, ram_rdata;
    logic [IDX_W-1:0] idx;
    logic [63:0]      lflags, base;

    fpt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
        end
        r_cmd  <= n_cmd;
        r_va   <= n_va;
        r_pf   <= n_pf;
        r_prot <= n_prot;
        r_lvl  <= n_lvl;
        r_tbl  <= n_tbl;
        r_res  <= n_res;
    end

    always_comb begin
        idx    = r_va[12 + 9*r_lvl +: 9];
        lflags = leaf_flags(r_prot);
        base   = 64'h3 | (lflags & 64'h4);
        n_state = r_state;
        n_clr   = r_clr;
        n_free  = r_free;
        n_cmd   = r_cmd;
        n_va    = r_va;
        n_pf    = r_pf;
        n_prot  = r_prot;
        n_lvl   = r_lvl;
        n_tbl   = r_tbl;
        n_res   = r_res;
        ram_we    = 1'b0;
        ram_addr  = {r_tbl, idx};
        ram_wdata = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tdata[1:0];
                    n_va    = s_axis_tdata[49:2];
                    n_pf    = s_axis_tdata[89:50];
                    n_prot  = s_axis_tdata[92:90];
                    n_lvl   = 2'd3;
                    n_tbl   = '0;
                    n_res   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_WAIT;
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (r_lvl != 2'd0) begin
                    if (ram_rdata[0]) begin
                        n_tbl   = ram_rdata[12 +: TF_W];
                        n_lvl   = r_lvl - 2'd1;
                        n_state = S_READ;
                    end else if (r_cmd != CMD_MAP) begin
                        n_res.status = ST_ABSENT;
                        n_state      = S_OUT;
                    end else if (r_free >= CNT_W'(TABLE_FRAMES)) begin
                        n_res.status = ST_NO_SPACE;
                        n_state      = S_OUT;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = (64'(r_free) << 12) | base;
                        n_free    = r_free + CNT_W'(1);
                        n_tbl     = r_free[TF_W-1:0];
                        n_lvl     = r_lvl - 2'd1;
                        n_state   = S_READ;
                    end
                end else begin
                    n_state = S_OUT;
                    if (r_cmd == CMD_MAP) begin
                        if (ram_rdata[0]) begin
                            n_res.status = ST_MAPPED;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = (64'(r_pf) << 12) | lflags;
                        end
                    end else if (!ram_rdata[0]) begin
                        n_res.status = ST_ABSENT;
                    end else begin
                        case (r_cmd)
                            CMD_UNMAP: begin
                                n_res.old_frame   = ram_rdata[51:12];
                                n_res.old_flags   = ram_rdata[11:0];
                                n_res.old_no_exec = ram_rdata[63];
                                n_res.tlb_flush   = 1'b1;
                                ram_we            = 1'b1;
                            end
                            CMD_TRANSLATE: begin
                                n_res.xlat_addr = {ram_rdata[51:12], r_va[11:0]};
                            end
                            default: begin
                                ram_we    = 1'b1;
                                ram_wdata = (ram_rdata & 64'h000F_FFFF_FFFF_F000)
                                            | lflags;
                                n_res.tlb_flush = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign m_axis_tdata = {4'd0, r_res.tlb_flush, r_res.old_no_exec, r_res.old_flags,
                           r_res.old_frame, r_res.xlat_addr, r_res.status};
endmodule
`default_nettype wire

// ----- tb/sv/four_level_page_table_engine_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_engine_checker
// Watches both stream channels, keeps a shadow page table and compares every
// result transaction against the predicted one.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_checker
    import fpt_pkg::*;
#(
    parameter int unsigned TABLE_FRAMES = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cmd_valid,
    input  wire          i_cmd_ready,
    input  wire  [95:0]  i_cmd_data,
    input  wire          i_res_valid,
    input  wire          i_res_ready,
    input  wire  [111:0] i_res_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [1:0]      status;
        logic [PA_W-1:0] xlat_addr;
        logic [PF_W-1:0] old_frame;
        logic [11:0]     old_flags;
        logic            old_no_exec;
        logic            tlb_flush;
    } t_walk_result;

    logic [63:0]  shadow_table [TABLE_FRAMES*512];
    int unsigned  next_table;
    t_walk_result walk_results_q[$];

    function automatic logic [63:0] prot_to_leaf(input logic [2:0] prot);
        logic [63:0] f;
        f     = 64'd1;
        f[1]  = prot[0];
        f[2]  = prot[1];
        f[63] = ~prot[2];
        return f;
    endfunction

    function automatic int unsigned entry_slot(input int unsigned tbl,
                                               input logic [47:0] va, input int lv);
        logic [8:0] idx;
        idx = va[12 + 9*(lv-1) +: 9];
        return (tbl % TABLE_FRAMES) * 512 + idx;
    endfunction

    function automatic int unsigned table_of(input logic [63:0] e);
        return 32'(e[51:12] % TABLE_FRAMES);
    endfunction

    task automatic walk_command(input logic [95:0] d);
        t_cmd         cmd;
        logic [47:0]  va;
        logic [39:0]  pf;
        logic [2:0]   prot;
        logic [63:0]  flags;
        logic [63:0]  e;
        int unsigned  tbl;
        int unsigned  s;
        bit           ok;
        t_walk_result r;
        cmd  = t_cmd'(d[1:0]);
        va   = d[49:2];
        pf   = d[89:50];
        prot = d[92:90];
        r    = '0;
        r.status = ST_OK;
        tbl  = 0;
        ok   = 1;
        if (cmd == CMD_MAP) begin
            flags = prot_to_leaf(prot);
            for (int lv = 4; lv > 1; lv--) begin
                s = entry_slot(tbl, va, lv);
                if (!shadow_table[s][0]) begin
                    if (next_table >= TABLE_FRAMES) begin
                        ok = 0;
                        break;
                    end
                    shadow_table[s] = (64'(next_table) << 12) | 64'h3 | (flags & 64'h4);
                    next_table++;
                end
                tbl = table_of(shadow_table[s]);
            end
            if (!ok) r.status = ST_NO_SPACE;
            else begin
                s = entry_slot(tbl, va, 1);
                if (shadow_table[s][0]) r.status = ST_MAPPED;
                else shadow_table[s] = (64'(pf) << 12) | flags;
            end
        end else begin
            for (int lv = 4; lv > 1; lv--) begin
                e = shadow_table[entry_slot(tbl, va, lv)];
                if (!e[0]) begin
                    ok = 0;
                    break;
                end
                tbl = table_of(e);
            end
            s = entry_slot(tbl, va, 1);
            if (!ok || !shadow_table[s][0]) r.status = ST_ABSENT;
            else begin
                e = shadow_table[s];
                case (cmd)
                    CMD_UNMAP: begin
                        r.old_frame   = e[51:12];
                        r.old_flags   = e[11:0];
                        r.old_no_exec = e[63];
                        r.tlb_flush   = 1'b1;
                        shadow_table[s] = '0;
                    end
                    CMD_TRANSLATE: begin
                        r.xlat_addr = {e[51:12], va[11:0]};
                    end
                    default: begin
                        shadow_table[s] = {12'd0, e[51:12], 12'd0} | prot_to_leaf(prot);
                        r.tlb_flush = 1'b1;
                    end
                endcase
            end
        end
        walk_results_q.push_back(r);
    endtask

    task automatic compare_result(input logic [111:0] d);
        t_walk_result exp_r;
        t_walk_result got;
        got.status      = d[1:0];
        got.xlat_addr   = d[53:2];
        got.old_frame   = d[93:54];
        got.old_flags   = d[105:94];
        got.old_no_exec = d[106];
        got.tlb_flush   = d[107];
        if (walk_results_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("unexpected result transaction: %h", d);
            return;
        end
        exp_r = walk_results_q.pop_front();
        if (got !== exp_r) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("result differs: exp st=%0d pa=%h of=%h fl=%h nx=%b tf=%b",
                         exp_r.status, exp_r.xlat_addr, exp_r.old_frame,
                         exp_r.old_flags, exp_r.old_no_exec, exp_r.tlb_flush);
                $display("                got st=%0d pa=%h of=%h fl=%h nx=%b tf=%b",
                         got.status, got.xlat_addr, got.old_frame,
                         got.old_flags, got.old_no_exec, got.tlb_flush);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        next_table   = 1;
        foreach (shadow_table[i]) shadow_table[i] = '0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cmd_valid && i_cmd_ready) walk_command(i_cmd_data);
            if (i_res_valid && i_res_ready) compare_result(i_res_data);
            o_pending = walk_results_q.size();
        end
    end

endmodule

// ----- tb/sv/four_level_page_table_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_engine_tb
// Drives directed and random page table commands with random gaps and stalls;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_tb;
    import fpt_pkg::*;

    localparam int unsigned TABLE_FRAMES = 64;
    localparam int          IDLE_LIMIT   = 60000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [111:0]  m_axis_tdata;
    int            fail_count;
    int            pending;
    int            idle_cycles = 0;
    bit            hold_off = 0;
    bit            long_hold_done = 0;
    logic [47:0]   used_va[$];

    always #5 i_clk = ~i_clk;

    four_level_page_table_engine #(.TABLE_FRAMES(TABLE_FRAMES)) i_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    four_level_page_table_engine_checker #(.TABLE_FRAMES(TABLE_FRAMES)) i_checker (
        .i_clk, .i_rst_n,
        .i_cmd_valid(s_axis_tvalid), .i_cmd_ready(s_axis_tready), .i_cmd_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Send one command transaction; valid stays high if another follows with no gap.
    task automatic send_cmd(input t_cmd cmd, input logic [47:0] va,
                            input logic [39:0] pf, input logic [2:0] prot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, prot, pf, va, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_MAP) used_va.push_back(va);
    endtask

    function automatic logic [47:0] rand_va();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [39:0] rand_pf();
        return 40'({$urandom(), $urandom()});
    endfunction

    // Reuse earlier addresses and a small set of top-level slots so tables fill up.
    function automatic logic [47:0] pick_va();
        logic [47:0] va;
        int k;
        k = $urandom_range(0, 9);
        if (k < 5 && used_va.size() > 0) begin
            va = used_va[$urandom_range(0, used_va.size() - 1)];
            va[11:0] = 12'($urandom());
        end else if (k < 8) begin
            va = rand_va();
            va[47:39] = 9'($urandom_range(0, 3));
            va[38:30] = 9'($urandom_range(0, 3));
            va[29:21] = 9'($urandom_range(0, 7));
        end else va = rand_va();
        return va;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off && !long_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold_done = 1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog on transaction progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT + TABLE_FRAMES * 512) begin
            $display("four_level_page_table_engine: mismatch");
            $finish;
        end
    end

    initial begin
        logic [47:0] va;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, absent walk, double map, user bit.
        va = '1;
        send_cmd(CMD_TRANSLATE, va, '0, 3'd0);
        send_cmd(CMD_UNMAP, va, '0, 3'd0);
        send_cmd(CMD_PROTECT, va, '0, 3'd7);
        send_cmd(CMD_MAP, va, '1, 3'd7);
        send_cmd(CMD_MAP, va, 40'h1, 3'd0);
        send_cmd(CMD_TRANSLATE, va, '0, 3'd0);
        send_cmd(CMD_PROTECT, va, '0, 3'd2);
        send_cmd(CMD_TRANSLATE, va, '0, 3'd0);
        send_cmd(CMD_UNMAP, va, '0, 3'd0);
        send_cmd(CMD_UNMAP, va, '0, 3'd0);
        send_cmd(CMD_MAP, 48'd0, '0, 3'd2);
        send_cmd(CMD_MAP, 48'h1000, 40'h5555555555, 3'd1);
        send_cmd(CMD_MAP, 48'h0000_4000_0000, 40'hAAAAAAAAAA, 3'd4);
        send_cmd(CMD_TRANSLATE, 48'h0000_4000_0ABC, '0, 3'd0);
        send_cmd(CMD_TRANSLATE, 48'h0000_0000_0FFF, '0, 3'd0);
        send_cmd(CMD_PROTECT, 48'h1000, '0, 3'd6);
        send_cmd(CMD_UNMAP, 48'h1000, '0, 3'd0);
        send_cmd(CMD_TRANSLATE, 48'h2000, '0, 3'd0);
        drain();

        // Long receiver hold-off while commands keep coming.
        hold_off = 1;
        for (int i = 0; i < 20; i++)
            send_cmd(t_cmd'($urandom_range(0, 3)), pick_va(), rand_pf(),
                     3'($urandom()));
        hold_off = 0;

        for (int i = 0; i < 780; i++) begin
            if (i == 400) drain();
            send_cmd(t_cmd'($urandom_range(0, 3)), pick_va(), rand_pf(),
                     3'($urandom()));
        end
        // Table frames are likely exhausted now; keep mapping fresh addresses.
        for (int i = 0; i < 10; i++)
            send_cmd(CMD_MAP, rand_va(), rand_pf(), 3'($urandom()));
        drain();

        if (fail_count == 0) $display("four_level_page_table_engine: match");
        else $display("four_level_page_table_engine: mismatch");
        $finish;
    end

endmodule
